// File: hdl/irsi_pkg.sv
// ----------------------------------------------------------------------------
// irsi_pkg: shared types for the interval run set index
// Request and response structs, request and status codes, run entry type.
// ----------------------------------------------------------------------------
package irsi_pkg;

  localparam int unsigned SLOT_W  = 16;
  localparam int unsigned COUNT_W = 17;

  localparam logic [2:0] REQ_REGISTER = 3'd0;
  localparam logic [2:0] REQ_WITHDRAW = 3'd1;
  localparam logic [2:0] REQ_WD_ALL   = 3'd2;
  localparam logic [2:0] REQ_TEST     = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNDECLARED = 3'd1;
  localparam logic [2:0] ST_NOT_REG    = 3'd2;
  localparam logic [2:0] ST_CONFLICT   = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [1:0]        subset;
    logic [SLOT_W-1:0] slot_index;
    logic              identity_declared;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               is_member;
    logic [COUNT_W-1:0] member_count;
  } rsp_t;

  typedef struct packed {
    logic [SLOT_W-1:0] first;
    logic [SLOT_W-1:0] last;
  } run_t;

  // Per-pass command codes for the cell chain.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SCAN,
    CMD_SHIFT
  } cell_op_t;

endpackage

// File: hdl/irsi_cell.sv
// ----------------------------------------------------------------------------
// irsi_cell: one run slot of the chain
// Holds one run entry; loads d when load is set (a neighbor's entry on a shift).
// ----------------------------------------------------------------------------
module irsi_cell
  import irsi_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  run_t d,
  output run_t q
);

  run_t ent;

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= d;
    end
  end

  assign q = ent;

endmodule

// File: hdl/interval_run_set_index_unit.sv
// ----------------------------------------------------------------------------
// interval_run_set_index_unit: per-subset sorted run tables
// Register, withdraw, withdraw-all, test and clear over chains of run cells.
// ----------------------------------------------------------------------------
//  channel   | signals                      | transfer
//  request   | start, busy, req             | start & !busy
//  response  | done, rsp                    | done (one cycle)
//  config    | cfg_we, cfg_wdata            | cfg_we
//
// A subset pass scans its chain cell by cell (a registered read of the cell,
// then a compare), then decides and, when entries must move for an insert,
// merge, erase or split, shifts them one neighbor transfer at a time, then
// writes any new runs and steps on. A register first makes a check pass over
// each exclusive subset. Reset (rst) clears every run count, member count and
// the exclusion matrix. Results cannot be stalled.
module interval_run_set_index_unit
  import irsi_pkg::*;
#(
  parameter int unsigned SUBSETS  = 4,
  parameter int unsigned MAX_RUNS = 64,
  parameter int unsigned SLOT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int unsigned CW = $clog2(MAX_RUNS + 1);
  localparam int unsigned SW = (SUBSETS > 1) ? $clog2(SUBSETS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_CMP, S_DECIDE, S_SHIFT, S_WRITE, S_NEXT, S_DONE
  } state_t;

  state_t state;
  logic [15:0] excl;
  logic [CW-1:0] rcnt [SUBSETS];
  logic [COUNT_W-1:0] mcnt [SUBSETS];

  req_t r;
  logic [SLOT_W-1:0] idx;
  logic [SW-1:0] cur;           // subset being worked on
  logic [IW-1:0] pos;           // scan read address
  logic [CW-1:0] fpos;          // found index
  logic [IW-1:0] sh;            // shift pointer
  logic          sh_up;
  logic [CW-1:0] sh_end;
  logic          check_mode;    // scanning for exclusion test (also set for a test request)
  logic [2:0]    status;
  logic          member;
  run_t          wr_a, wr_b;
  logic [CW-1:0] wa_pos;
  logic          wr_a_en, wr_b_en;
  run_t          rd_q;          // cell at fpos, registered in S_SCAN
  run_t          prev_q;        // cell just below fpos

  // Chains: one per subset, entries shifted between neighboring cells.
  run_t cq [SUBSETS][MAX_RUNS];
  run_t cd [SUBSETS][MAX_RUNS];
  logic cl [SUBSETS][MAX_RUNS];

  for (genvar s = 0; s < SUBSETS; s++) begin : g_s
    for (genvar k = 0; k < MAX_RUNS; k++) begin : g_k
      irsi_cell u_cell (.clk(clk), .load(cl[s][k]), .d(cd[s][k]), .q(cq[s][k]));
    end
  end

  // Neighbor transfer: shift up takes from k-1, shift down from k+1.
  always_comb begin
    for (int s = 0; s < SUBSETS; s++) begin
      for (int k = 0; k < MAX_RUNS; k++) begin
        cl[s][k] = 1'b0;
        cd[s][k] = cq[s][k];
        if (s == int'(cur)) begin
          if (state == S_SHIFT) begin
            if (sh_up && k == int'(sh) && k > 0) begin
              cl[s][k] = 1'b1;
              cd[s][k] = cq[s][(k > 0) ? k - 1 : 0];
            end else if (!sh_up && k == int'(sh) && k + 1 < MAX_RUNS) begin
              cl[s][k] = 1'b1;
              cd[s][k] = cq[s][(k + 1 < MAX_RUNS) ? k + 1 : k];
            end
          end else if (state == S_WRITE) begin
            if (wr_a_en && k == int'(wa_pos)) begin
              cl[s][k] = 1'b1;
              cd[s][k] = wr_a;
            end else if (wr_b_en && k == int'(wa_pos) + 1) begin
              cl[s][k] = 1'b1;
              cd[s][k] = wr_b;
            end
          end
        end
      end
    end
  end

  logic [CW-1:0] n_cur;
  logic          cur_excl, f_in, f_hit, bl, ab;

  assign n_cur    = rcnt[cur];
  assign cur_excl = (32'(cur) < 4) && excl[4'((32'(r.subset) << 2) + 32'(cur))];
  assign f_in     = fpos < n_cur;
  assign f_hit    = f_in && rd_q.first <= idx;
  // The new slot touches the run below it or the run above it.
  assign bl = (fpos != '0) && ({1'b0, prev_q.last} + 17'd1 == {1'b0, idx});
  assign ab = f_in && ({1'b0, rd_q.first} == {1'b0, idx} + 17'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      state      <= S_IDLE;
      excl       <= '0;
      r          <= '0;
      cur        <= '0;
      status     <= ST_OK;
      member     <= 1'b0;
      check_mode <= 1'b0;
      wr_a_en    <= 1'b0;
      wr_b_en    <= 1'b0;
      for (int s = 0; s < SUBSETS; s++) begin
        rcnt[s] <= '0;
        mcnt[s] <= '0;
      end
    end else begin
      done <= (state == S_DONE);
      if (cfg_we) excl <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r      <= req;
            idx    <= SLOT_W'(req.slot_index[SLOT_BITS-1:0]);
            member <= 1'b0;
            pos    <= '0;
            fpos   <= '0;
            if (32'(req.subset) >= SUBSETS) begin
              status <= ST_OK;
              state  <= S_DONE;
            end else begin
              unique case (req.req_type)
                REQ_REGISTER: begin
                  if (!req.identity_declared) begin
                    status <= ST_UNDECLARED; state <= S_DONE;
                  end else begin
                    status <= ST_OK;
                    cur <= '0; check_mode <= 1'b1; state <= S_CHECK;
                  end
                end
                REQ_WITHDRAW: begin
                  if (!req.identity_declared) begin
                    status <= ST_UNDECLARED; state <= S_DONE;
                  end else begin
                    status <= ST_OK;
                    cur <= SW'(req.subset); check_mode <= 1'b0; state <= S_SCAN;
                  end
                end
                REQ_WD_ALL: begin
                  if (!req.identity_declared) begin
                    status <= ST_UNDECLARED; state <= S_DONE;
                  end else begin
                    status <= ST_OK;
                    cur <= '0; check_mode <= 1'b0; state <= S_SCAN;
                  end
                end
                REQ_TEST: begin
                  status <= ST_OK;
                  if (req.identity_declared) begin
                    cur <= SW'(req.subset); check_mode <= 1'b1; state <= S_SCAN;
                  end else state <= S_DONE;
                end
                REQ_CLEAR: begin
                  status <= ST_OK;
                  rcnt[req.subset[SW-1:0]] <= '0;
                  mcnt[req.subset[SW-1:0]] <= '0;
                  state <= S_DONE;
                end
                default: begin
                  status <= ST_OK;
                  state  <= S_DONE;
                end
              endcase
            end
          end
        end
        S_CHECK: begin
          // Exclusion test of subset cur; skip when not exclusive.
          if (cur_excl) begin
            pos <= '0; fpos <= '0; state <= S_SCAN;
          end else if (32'(cur) + 1 < SUBSETS) cur <= cur + SW'(1);
          else begin
            cur <= SW'(r.subset); check_mode <= 1'b0;
            pos <= '0; fpos <= '0; state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_q  <= cq[cur][pos];
          state <= S_CMP;
        end
        S_CMP: begin
          // Step on until a run whose last is not below idx, or past the last run.
          if (fpos < n_cur && rd_q.last < idx) begin
            prev_q <= rd_q;
            fpos   <= fpos + CW'(1);
            pos    <= pos + IW'(1);
            state  <= S_SCAN;
          end else state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (r.req_type == REQ_TEST) begin
            member <= f_hit;
            state  <= S_DONE;
          end else if (r.req_type == REQ_REGISTER && check_mode) begin
            if (f_hit) begin
              status <= ST_CONFLICT; state <= S_DONE;
            end else state <= S_NEXT;
          end else if (r.req_type == REQ_REGISTER) begin
            if (f_hit) begin
              state <= S_DONE;
            end else if (bl && ab) begin
              mcnt[cur] <= mcnt[cur] + COUNT_W'(1);
              wa_pos <= fpos - CW'(1); wr_a_en <= 1'b1;
              wr_a <= '{first: prev_q.first, last: rd_q.last};
              sh <= fpos[IW-1:0]; sh_up <= 1'b0; sh_end <= n_cur;
              rcnt[cur] <= n_cur - CW'(1);
              state <= S_SHIFT;
            end else if (bl) begin
              mcnt[cur] <= mcnt[cur] + COUNT_W'(1);
              wa_pos <= fpos - CW'(1); wr_a_en <= 1'b1;
              wr_a <= '{first: prev_q.first, last: idx};
              state <= S_WRITE;
            end else if (ab) begin
              mcnt[cur] <= mcnt[cur] + COUNT_W'(1);
              wa_pos <= fpos; wr_a_en <= 1'b1;
              wr_a <= '{first: idx, last: rd_q.last};
              state <= S_WRITE;
            end else if (n_cur >= CW'(MAX_RUNS)) begin
              status <= ST_FULL;
              state  <= S_DONE;
            end else begin
              mcnt[cur] <= mcnt[cur] + COUNT_W'(1);
              wa_pos <= fpos; wr_a_en <= 1'b1;
              wr_a <= '{first: idx, last: idx};
              sh <= IW'(n_cur); sh_up <= 1'b1; sh_end <= fpos;
              rcnt[cur] <= n_cur + CW'(1);
              state <= (n_cur == fpos) ? S_WRITE : S_SHIFT;
            end
          end else begin
            // Withdraw from subset cur.
            if (!f_hit) begin
              if (r.req_type == REQ_WITHDRAW) status <= ST_NOT_REG;
              state <= S_NEXT;
            end else if (rd_q.first == idx && rd_q.last == idx) begin
              mcnt[cur] <= mcnt[cur] - COUNT_W'(1);
              sh <= fpos[IW-1:0]; sh_up <= 1'b0; sh_end <= n_cur;
              rcnt[cur] <= n_cur - CW'(1);
              state <= S_SHIFT;
            end else if (rd_q.first == idx) begin
              mcnt[cur] <= mcnt[cur] - COUNT_W'(1);
              wa_pos <= fpos; wr_a_en <= 1'b1;
              wr_a <= '{first: idx + SLOT_W'(1), last: rd_q.last};
              state <= S_WRITE;
            end else if (rd_q.last == idx) begin
              mcnt[cur] <= mcnt[cur] - COUNT_W'(1);
              wa_pos <= fpos; wr_a_en <= 1'b1;
              wr_a <= '{first: rd_q.first, last: idx - SLOT_W'(1)};
              state <= S_WRITE;
            end else if (n_cur >= CW'(MAX_RUNS)) begin
              status <= ST_FULL;
              state  <= S_NEXT;
            end else begin
              mcnt[cur] <= mcnt[cur] - COUNT_W'(1);
              wa_pos <= fpos; wr_a_en <= 1'b1; wr_b_en <= 1'b1;
              wr_a <= '{first: rd_q.first, last: idx - SLOT_W'(1)};
              wr_b <= '{first: idx + SLOT_W'(1), last: rd_q.last};
              sh <= IW'(n_cur); sh_up <= 1'b1; sh_end <= fpos + CW'(1);
              rcnt[cur] <= n_cur + CW'(1);
              state <= (n_cur == fpos + CW'(1)) ? S_WRITE : S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          // Shift pass: one neighbor transfer per cycle.
          if (sh_up) begin
            if (CW'(sh) <= sh_end + CW'(1) || sh == '0) state <= S_WRITE;
            else sh <= sh - IW'(1);
          end else begin
            if (CW'(sh) + CW'(2) >= sh_end) state <= S_WRITE;
            else sh <= sh + IW'(1);
          end
        end
        S_WRITE: begin
          wr_a_en <= 1'b0;
          wr_b_en <= 1'b0;
          state   <= S_NEXT;
        end
        S_NEXT: begin
          if (r.req_type == REQ_WD_ALL && 32'(cur) + 1 < SUBSETS) begin
            cur <= cur + SW'(1); pos <= '0; fpos <= '0; state <= S_SCAN;
          end else if (r.req_type == REQ_REGISTER && check_mode) begin
            if (32'(cur) + 1 < SUBSETS) begin
              cur <= cur + SW'(1); state <= S_CHECK;
            end else begin
              cur <= SW'(r.subset); check_mode <= 1'b0;
              pos <= '0; fpos <= '0; state <= S_SCAN;
            end
          end else state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Withdraw-all with a full refusal must still report ST_FULL; status holds
  // across subsets since only refusals write it for that request type.
  assign busy = (state != S_IDLE);
  always_comb begin
    rsp.status       = status;
    rsp.is_member    = member;
    rsp.member_count = (32'(r.subset) < SUBSETS) ? mcnt[r.subset[SW-1:0]] : '0;
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("start not taken");
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    rcnt[cur] <= CW'(MAX_RUNS)) else $error("run count overflow");

endmodule
